// ===== src/process_id_table_top_assert.svh =====
// Assertion macros for the process id table.
`ifndef PROCESS_ID_TABLE_TOP_ASSERT_SVH
`define PROCESS_ID_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define PIT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("process id table assertion failed");
`define PIT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("process id table assertion failed");
`else
`define PIT_ASSERT_NOW(label, ante, cons)
`define PIT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/pit_pkg.sv =====
// Shared constants, codes and types for the process id table.
`default_nettype none

package pit_pkg;

    localparam int SLOT_BITS_DEF  = 10;
    localparam int ASID_COUNT_DEF = 64;

    localparam int ID_W         = 17;
    localparam int SLOT_W       = 10;
    localparam int OP_W         = 2;
    localparam int STAT_W       = 2;
    localparam int ASID_FIELD_W = 6;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;
    localparam logic [OP_W-1:0] OP_SET_CUR = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_SLOT = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_ASID = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   lid;
        logic [SLOT_W-1:0] sidx;
        logic [ID_W-1:0]   parent;
        logic              perm;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   proc_id;
        logic [SLOT_W-1:0] found_slot;
        logic              has_proc;
    } res_t;

endpackage

`default_nettype wire

// ===== src/process_id_table_top.sv =====
// Process slot table with free-slot stack and ASID bitmap.
//
//  channel | signals                                                 | dir
//  --------+---------------------------------------------------------+-----
//  in      | in_valid, in_stall, opcode, lookup_id, slot_index,      | in
//          | parent_ident, check_perm                                |
//  out     | out_valid, out_stall, status, proc_id, found_slot,      | out
//          | has_proc                                                |
//
//  The transfer edge of a request reads the slot memory and the free-stack memory;
//  a later edge, held off while a stalled result waits, checks, writes back, pushes
//  or pops and loads the result register. A new transfer is taken the cycle after.
//  No clearing pass after reset: a fill mark on the free stack tells which
//  stack entries and which slot entries have never been written.
//  A result held by out_stall delays completion of the next request only.
`default_nettype none

module process_id_table_top
    import pit_pkg::*;
#(
    parameter int SLOT_BITS  = SLOT_BITS_DEF,
    parameter int ASID_COUNT = ASID_COUNT_DEF
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic [ID_W-1:0]   lookup_id,
    input  wire logic [SLOT_W-1:0] slot_index,
    input  wire logic [ID_W-1:0]   parent_ident,
    input  wire logic              check_perm,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [STAT_W-1:0]      status,
    output logic [ID_W-1:0]        proc_id,
    output logic [SLOT_W-1:0]      found_slot,
    output logic                   has_proc
);

`include "process_id_table_top_assert.svh"

    localparam int NSLOT  = 1 << SLOT_BITS;
    localparam int CNT_W  = SLOT_BITS + 1;
    localparam int ENT_W  = 1 + 2 * ID_W;
    localparam int FULL_W = ASID_FIELD_W + 1 + SLOT_BITS;
    localparam int CMP_W  = ((SLOT_BITS > SLOT_W) ? SLOT_BITS : SLOT_W) + 1;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    logic [ENT_W-1:0]     slot_ram [NSLOT];
    logic [SLOT_BITS-1:0] stack_ram [NSLOT];
    logic [ENT_W-1:0]     slot_rd_reg;
    logic [SLOT_BITS-1:0] stack_rd_reg;

    logic [0:0]           state_reg, state_next;
    req_t                 req_reg;
    logic [CNT_W-1:0]     fc_reg, fc_next;
    logic [CNT_W-1:0]     low_reg, low_next;
    logic [ASID_COUNT-1:0] asid_reg, asid_next;
    logic [SLOT_BITS-1:0] cur_slot_reg, cur_slot_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [ID_W-1:0]      cur_ident_reg, cur_ident_next;
    logic                 out_valid_reg, out_valid_next;
    res_t                 res_reg, res_next;

    logic                 accept;
    logic                 done;
    logic [SLOT_BITS-1:0] slot_ra;
    logic [SLOT_BITS-1:0] stack_ra;
    logic                 slot_we;
    logic [SLOT_BITS-1:0] slot_wa;
    logic [ENT_W-1:0]     slot_wd;
    logic                 stack_we;
    logic [SLOT_BITS-1:0] stack_wa;
    logic [SLOT_BITS-1:0] stack_wd;

    logic                 rd_live;
    logic [ID_W-1:0]      rd_ident;
    logic [ID_W-1:0]      rd_parent;
    logic [SLOT_BITS-1:0] req_slot;
    logic [CNT_W-1:0]     fresh_lim;
    logic                 live;
    logic                 in_range;
    logic [ASID_COUNT-1:0] asid_free_oh;
    logic                 asid_full;
    logic [ASID_FIELD_W-1:0] asid_idx;
    logic                 pop_fresh;
    logic [SLOT_BITS-1:0] pop_slot;
    logic [FULL_W-1:0]    alloc_full;
    logic [ID_W-1:0]      alloc_id;
    logic [ASID_FIELD_W-1:0] free_asid;
    logic                 free_asid_ok;
    logic [ASID_COUNT-1:0] free_mask;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign done     = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    assign slot_ra  = (opcode == OP_LOOKUP) ? SLOT_BITS'(lookup_id)
                                            : SLOT_BITS'(slot_index);
    assign stack_ra = SLOT_BITS'(fc_reg - CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_ram[slot_wa] <= slot_wd;
        end
        if (accept)
        begin
            slot_rd_reg <= slot_ram[slot_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_ram[stack_wa] <= stack_wd;
        end
        if (accept)
        begin
            stack_rd_reg <= stack_ram[stack_ra];
        end
    end

    assign rd_live   = slot_rd_reg[ENT_W-1];
    assign rd_ident  = slot_rd_reg[2*ID_W-1:ID_W];
    assign rd_parent = slot_rd_reg[ID_W-1:0];

    assign req_slot  = (req_reg.op == OP_LOOKUP) ? SLOT_BITS'(req_reg.lid)
                                                 : SLOT_BITS'(req_reg.sidx);
    // slots at or above NSLOT minus the fill mark were never handed out
    assign fresh_lim = CNT_W'(NSLOT) - low_reg;
    assign live      = rd_live && (CNT_W'(req_slot) < fresh_lim);
    assign in_range  = CMP_W'(req_reg.sidx) < CMP_W'(NSLOT);

    assign asid_free_oh = ~asid_reg & (asid_reg + ASID_COUNT'(1));
    assign asid_full    = &asid_reg;

    always_comb
    begin
        asid_idx = '0;
        for (int i = 0; i < ASID_COUNT; i++)
        begin
            if (asid_free_oh[i])
            begin
                asid_idx = asid_idx | ASID_FIELD_W'(i);
            end
        end
    end

    assign pop_fresh  = (fc_reg == low_reg);
    assign pop_slot   = pop_fresh ? SLOT_BITS'(CNT_W'(NSLOT) - fc_reg) : stack_rd_reg;
    assign alloc_full = {asid_idx, 1'b1, pop_slot};
    assign alloc_id   = ID_W'(alloc_full);

    assign free_asid    = ASID_FIELD_W'(rd_ident >> (SLOT_BITS + 1));
    assign free_asid_ok = (ASID_FIELD_W + 1)'(free_asid) < (ASID_FIELD_W + 1)'(ASID_COUNT);
    assign free_mask    = free_asid_ok ? (ASID_COUNT'(1) << free_asid) : '0;

    always_comb
    begin
        state_next     = state_reg;
        fc_next        = fc_reg;
        low_next       = low_reg;
        asid_next      = asid_reg;
        cur_slot_next  = cur_slot_reg;
        cur_valid_next = cur_valid_reg;
        cur_ident_next = cur_ident_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_next       = res_reg;
        slot_we        = 1'b0;
        slot_wa        = req_slot;
        slot_wd        = slot_rd_reg;
        stack_we       = 1'b0;
        stack_wa       = SLOT_BITS'(fc_reg);
        stack_wd       = req_slot;

        if (accept)
        begin
            state_next = S_EXEC;
        end

        if (done)
        begin
            state_next     = S_IDLE;
            out_valid_next = 1'b1;
            res_next       = '{status: STAT_BAD, proc_id: '0, found_slot: '0, has_proc: 1'b0};
            case (req_reg.op)
                OP_ALLOC:
                begin
                    if (fc_reg == '0)
                    begin
                        res_next.status = STAT_NO_SLOT;
                    end
                    else if (asid_full)
                    begin
                        res_next.status = STAT_NO_ASID;
                    end
                    else
                    begin
                        asid_next = asid_reg | asid_free_oh;
                        fc_next   = fc_reg - CNT_W'(1);
                        if (pop_fresh)
                        begin
                            low_next = fc_reg - CNT_W'(1);
                        end
                        slot_we  = 1'b1;
                        slot_wa  = pop_slot;
                        slot_wd  = {1'b1, alloc_id, req_reg.parent};
                        res_next = '{status: STAT_OK, proc_id: alloc_id,
                                     found_slot: SLOT_W'(pop_slot), has_proc: 1'b1};
                    end
                end
                OP_FREE:
                begin
                    if (in_range && live)
                    begin
                        slot_we   = 1'b1;
                        slot_wd   = {1'b0, rd_ident, rd_parent};
                        asid_next = asid_reg & ~free_mask;
                        if (fc_reg < CNT_W'(NSLOT))
                        begin
                            stack_we = 1'b1;
                            fc_next  = fc_reg + CNT_W'(1);
                        end
                        if (cur_valid_reg && (cur_slot_reg == req_slot))
                        begin
                            cur_valid_next = 1'b0;
                        end
                        res_next.status = STAT_OK;
                    end
                end
                OP_LOOKUP:
                begin
                    if (req_reg.lid == '0)
                    begin
                        res_next.status = STAT_OK;
                        if (cur_valid_reg)
                        begin
                            res_next.proc_id    = cur_ident_reg;
                            res_next.found_slot = SLOT_W'(cur_slot_reg);
                            res_next.has_proc   = 1'b1;
                        end
                    end
                    else if (live && (rd_ident == req_reg.lid) &&
                             (!req_reg.perm ||
                              (cur_valid_reg && ((req_slot == cur_slot_reg) ||
                                                 (rd_parent == cur_ident_reg)))))
                    begin
                        res_next = '{status: STAT_OK, proc_id: req_reg.lid,
                                     found_slot: SLOT_W'(req_slot), has_proc: 1'b1};
                    end
                end
                OP_SET_CUR:
                begin
                    if (in_range && live)
                    begin
                        cur_slot_next  = req_slot;
                        cur_valid_next = 1'b1;
                        cur_ident_next = rd_ident;
                        res_next = '{status: STAT_OK, proc_id: rd_ident,
                                     found_slot: SLOT_W'(req_slot), has_proc: 1'b1};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fc_reg        <= CNT_W'(NSLOT);
            low_reg       <= CNT_W'(NSLOT);
            asid_reg      <= '0;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fc_reg        <= fc_next;
            low_reg       <= low_next;
            asid_reg      <= asid_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= '{op: opcode, lid: lookup_id, sidx: slot_index,
                         parent: parent_ident, perm: check_perm};
        end
        cur_ident_reg <= cur_ident_next;
        res_reg       <= res_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = res_reg.status;
    assign proc_id    = res_reg.proc_id;
    assign found_slot = res_reg.found_slot;
    assign has_proc   = res_reg.has_proc;

    `PIT_ASSERT_NOW(a_mark_le_count, 1'b1, (low_reg <= fc_reg) && (fc_reg <= CNT_W'(NSLOT)))
    `PIT_ASSERT_NOW(a_cur_handed_out, cur_valid_reg, CNT_W'(cur_slot_reg) < fresh_lim)
    `PIT_ASSERT_NOW(a_fail_no_proc, out_valid_reg && (res_reg.status != STAT_OK), (res_reg.proc_id == '0) && !res_reg.has_proc && (res_reg.found_slot == '0))
    `PIT_ASSERT_NEXT(a_done_loads_result, done, out_valid_reg && (state_reg == S_IDLE))

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the process id table: directed table, then random traffic.
`timescale 1ns / 100ps

module tb;
    import pit_pkg::*;

    localparam int NSLOT       = 1 << SLOT_BITS_DEF;
    localparam int STUCK_LIMIT = 2000;
    localparam int ROUNDS      = 10;
    localparam int ROUND_ITEMS = 100;

    typedef struct {
        req_t rq;
        bit   typed;
        res_t rs;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   opcode = OP_ALLOC;
    logic [ID_W-1:0]   lookup_id = '0;
    logic [SLOT_W-1:0] slot_index = '0;
    logic [ID_W-1:0]   parent_ident = '0;
    logic              check_perm = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   proc_id;
    logic [SLOT_W-1:0] found_slot;
    logic              has_proc;

    bit [ID_W-1:0]     shadow_ident [NSLOT];
    bit                shadow_live [NSLOT];
    bit [ID_W-1:0]     shadow_parent [NSLOT];
    bit [SLOT_W-1:0]   shadow_stack [NSLOT];
    int                shadow_free_cnt;
    bit [63:0]         shadow_asid;
    bit [SLOT_W-1:0]   shadow_cur;
    bit                shadow_cur_ok;

    res_t              pending_res [$];
    dir_row_t          dir_rows [$];
    bit                cur_typed = 1'b0;
    res_t              cur_typed_res = '0;
    int                err_count = 0;
    int                stuck_cycles = 0;
    int                send_pct = 0;
    int                rcv_pct = 0;

    process_id_table_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .lookup_id    (lookup_id),
        .slot_index   (slot_index),
        .parent_ident (parent_ident),
        .check_perm   (check_perm),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .proc_id      (proc_id),
        .found_slot   (found_slot),
        .has_proc     (has_proc)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic res_t predict_table_op(input req_t rq);
        res_t r;
        int a;
        logic [SLOT_W-1:0] s;
        r = '0;
        r.status = STAT_OK;
        case (rq.op)
            OP_ALLOC:
            begin
                a = 0;
                while (a < ASID_COUNT_DEF && shadow_asid[a])
                    a++;
                if (shadow_free_cnt == 0)
                    r.status = STAT_NO_SLOT;
                else if (a == ASID_COUNT_DEF)
                    r.status = STAT_NO_ASID;
                else
                begin
                    shadow_asid[a] = 1'b1;
                    shadow_free_cnt--;
                    s = shadow_stack[shadow_free_cnt];
                    shadow_ident[s] = {a[ASID_FIELD_W-1:0], 1'b1, s};
                    shadow_parent[s] = rq.parent;
                    shadow_live[s] = 1'b1;
                    r = {STAT_OK, shadow_ident[s], s, 1'b1};
                end
            end
            OP_FREE:
            begin
                s = rq.sidx;
                if (!shadow_live[s])
                    r.status = STAT_BAD;
                else
                begin
                    shadow_live[s] = 1'b0;
                    shadow_asid[shadow_ident[s][ID_W-1 -: ASID_FIELD_W]] = 1'b0;
                    if (shadow_free_cnt < NSLOT)
                    begin
                        shadow_stack[shadow_free_cnt] = s;
                        shadow_free_cnt++;
                    end
                    if (shadow_cur_ok && shadow_cur == s)
                        shadow_cur_ok = 1'b0;
                end
            end
            OP_LOOKUP:
            begin
                s = rq.lid[SLOT_W-1:0];
                if (rq.lid == '0)
                begin
                    if (shadow_cur_ok)
                        r = {STAT_OK, shadow_ident[shadow_cur], shadow_cur, 1'b1};
                end
                else if (!shadow_live[s] || shadow_ident[s] != rq.lid)
                    r.status = STAT_BAD;
                else if (rq.perm && (!shadow_cur_ok ||
                         (s != shadow_cur && shadow_parent[s] != shadow_ident[shadow_cur])))
                    r.status = STAT_BAD;
                else
                    r = {STAT_OK, rq.lid, s, 1'b1};
            end
            default:
            begin
                s = rq.sidx;
                if (!shadow_live[s])
                    r.status = STAT_BAD;
                else
                begin
                    shadow_cur = s;
                    shadow_cur_ok = 1'b1;
                    r = {STAT_OK, shadow_ident[s], s, 1'b1};
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string what, input int unsigned want_v,
                                        input int unsigned got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        req_t taken;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_res.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual status %0d id %0d",
                             $time, status, proc_id);
                    err_count++;
                end
                else
                begin
                    want = pending_res.pop_front();
                    check_field("status", want.status, status);
                    check_field("proc_id", want.proc_id, proc_id);
                    check_field("found_slot", want.found_slot, found_slot);
                    check_field("has_proc", want.has_proc, has_proc);
                end
            end
            if (in_valid && !in_stall)
            begin
                taken = {opcode, lookup_id, slot_index, parent_ident, check_perm};
                want = predict_table_op(taken);
                pending_res.push_back(cur_typed ? cur_typed_res : want);
            end
        end
    end

    always @(negedge clk)
        out_stall <= (rcv_pct != 0) && ($urandom_range(0, 99) < rcv_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic add_row(input logic [OP_W-1:0] op, input int lid, input int sidx,
                           input int par, input bit perm, input bit typed,
                           input logic [STAT_W-1:0] st, input int id, input int slot,
                           input bit has);
        dir_row_t row;
        row.rq = {op, ID_W'(lid), SLOT_W'(sidx), ID_W'(par), perm};
        row.typed = typed;
        row.rs = {st, ID_W'(id), SLOT_W'(slot), has};
        dir_rows.push_back(row);
    endtask

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_req(input req_t rq, input bit typed, input res_t typed_res);
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        opcode <= rq.op;
        lookup_id <= rq.lid;
        slot_index <= rq.sidx;
        parent_ident <= rq.parent;
        check_perm <= rq.perm;
        cur_typed <= typed;
        cur_typed_res <= typed_res;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    initial
    begin
        req_t rq;
        res_t no_res;
        logic [SLOT_W-1:0] s;
        bit have_live;
        bit fill_mode;
        int pick;
        int start;

        for (int i = 0; i < NSLOT; i++)
        begin
            shadow_stack[i] = SLOT_W'(NSLOT - 1 - i);
            shadow_live[i] = 1'b0;
        end
        shadow_free_cnt = NSLOT;
        shadow_asid = '0;
        shadow_cur = '0;
        shadow_cur_ok = 1'b0;
        no_res = '0;
        fill_mode = 1'b1;

        add_row(OP_LOOKUP, 0, 0, 0, 0, 1, STAT_OK, 0, 0, 0);
        add_row(OP_LOOKUP, 131071, 1023, 131071, 1, 1, STAT_BAD, 0, 0, 0);
        add_row(OP_SET_CUR, 0, 1023, 0, 0, 1, STAT_BAD, 0, 0, 0);
        add_row(OP_FREE, 0, 0, 0, 0, 1, STAT_BAD, 0, 0, 0);
        add_row(OP_ALLOC, 0, 0, 0, 0, 1, STAT_OK, 1024, 0, 1);
        add_row(OP_ALLOC, 0, 0, 1024, 0, 1, STAT_OK, 3073, 1, 1);
        add_row(OP_ALLOC, 131071, 1023, 131071, 1, 1, STAT_OK, 5122, 2, 1);
        add_row(OP_LOOKUP, 3073, 0, 0, 1, 1, STAT_BAD, 0, 0, 0);
        add_row(OP_LOOKUP, 3073, 0, 0, 0, 1, STAT_OK, 3073, 1, 1);
        add_row(OP_LOOKUP, 1025, 0, 0, 0, 1, STAT_BAD, 0, 0, 0);
        add_row(OP_LOOKUP, 1, 0, 0, 0, 1, STAT_BAD, 0, 0, 0);
        add_row(OP_SET_CUR, 0, 0, 0, 0, 1, STAT_OK, 1024, 0, 1);
        add_row(OP_LOOKUP, 3073, 0, 0, 1, 0, STAT_OK, 0, 0, 0);
        add_row(OP_LOOKUP, 5122, 0, 0, 1, 0, STAT_OK, 0, 0, 0);
        add_row(OP_LOOKUP, 1024, 0, 0, 1, 0, STAT_OK, 0, 0, 0);
        add_row(OP_LOOKUP, 0, 0, 0, 1, 1, STAT_OK, 1024, 0, 1);
        add_row(OP_FREE, 0, 0, 0, 0, 1, STAT_OK, 0, 0, 0);
        add_row(OP_FREE, 0, 0, 0, 0, 1, STAT_BAD, 0, 0, 0);
        add_row(OP_LOOKUP, 0, 0, 0, 0, 1, STAT_OK, 0, 0, 0);
        add_row(OP_LOOKUP, 1024, 0, 0, 0, 1, STAT_BAD, 0, 0, 0);
        add_row(OP_ALLOC, 0, 0, 0, 0, 0, STAT_OK, 0, 0, 0);
        add_row(OP_FREE, 0, 1, 0, 0, 0, STAT_OK, 0, 0, 0);
        add_row(OP_ALLOC, 0, 0, 5122, 0, 0, STAT_OK, 0, 0, 0);
        add_row(OP_SET_CUR, 0, 2, 0, 0, 0, STAT_OK, 0, 0, 0);
        add_row(OP_FREE, 0, 2, 0, 0, 0, STAT_OK, 0, 0, 0);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        send_pct = 22;
        rcv_pct = 22;
        foreach (dir_rows[i])
            send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rs);

        for (int round = 0; round < ROUNDS; round++)
        begin
            // hold the sender until the table has drained
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while (pending_res.size() != 0);
            send_pct = (round % 4 == 1 || round % 4 == 3) ? ((round % 4 == 1) ? 49 : 22) : 0;
            rcv_pct = (round % 4 == 2 || round % 4 == 3) ? ((round % 4 == 2) ? 49 : 22) : 0;
            for (int n = 0; n < ROUND_ITEMS; n++)
            begin
                if (fill_mode && shadow_asid == '1 && $urandom_range(0, 3) == 0)
                    fill_mode = 1'b0;
                else if (!fill_mode && shadow_free_cnt == NSLOT)
                    fill_mode = 1'b1;

                rq.lid = ID_W'($urandom);
                rq.sidx = SLOT_W'($urandom);
                rq.parent = ID_W'($urandom);
                rq.perm = 1'($urandom_range(0, 1));

                have_live = 1'b0;
                s = '0;
                start = $urandom_range(0, NSLOT - 1);
                for (int k = 0; k < NSLOT && !have_live; k++)
                begin
                    s = SLOT_W'(start + k);
                    have_live = shadow_live[s];
                end

                pick = $urandom_range(0, 99);
                if (pick < (fill_mode ? 50 : 10))
                    rq.op = OP_ALLOC;
                else if (pick < 60)
                    rq.op = OP_FREE;
                else if (pick < 85)
                    rq.op = OP_LOOKUP;
                else
                    rq.op = OP_SET_CUR;

                pick = $urandom_range(0, 19);
                case (rq.op)
                    OP_ALLOC:
                    begin
                        if (pick < 8 && shadow_cur_ok)
                            rq.parent = shadow_ident[shadow_cur];
                        else if (pick < 14 && have_live)
                            rq.parent = shadow_ident[s];
                        else if (pick < 16)
                            rq.parent = '0;
                    end
                    OP_LOOKUP:
                    begin
                        if (pick < 2)
                            rq.lid = '0;
                        else if (pick < 14 && have_live)
                            rq.lid = shadow_ident[s];
                        else if (pick < 17 && have_live)
                            rq.lid = shadow_ident[s] ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
                    end
                    default:
                    begin
                        if (pick < 17 && have_live)
                            rq.sidx = s;
                    end
                endcase

                send_req(rq, 1'b0, no_res);
            end
        end

        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_res.size() != 0);
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== process_id_table_top.f =====
+incdir+src
src/pit_pkg.sv
src/process_id_table_top.sv
tb/tb.sv
